// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the glob matcher RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked, disabled in reset.
`define GPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication.
`define GPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/gpm_pkg.sv =====
// ---------------------------------------------------------------------------
// gpm_pkg
// Types and constants shared by the glob matcher modules.
// ---------------------------------------------------------------------------
package gpm_pkg;

  localparam int unsigned MaxElementsDef = 32;

  typedef enum logic [1:0] {
    OP_PAT_BYTE  = 2'd0,
    OP_PAT_END   = 2'd1,
    OP_TEXT_BYTE = 2'd2,
    OP_TEXT_END  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_LIT  = 2'd0,
    K_ANY  = 2'd1,
    K_STAR = 2'd2,
    K_LIST = 2'd3
  } kind_e;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [2:0] OCT_MAX_DIGITS = 3'd3;

  // Write command from the compiler to one cell.
  typedef struct packed {
    logic         elem_we;
    kind_e        kind;
    logic [7:0]   lit;
    logic         set_we;
    logic         negate;
    logic         clear;
    logic [255:0] mask;
  } cell_cmd_t;

endpackage

// ===== design/glob_pattern_matcher_unit.sv =====
// ---------------------------------------------------------------------------
// glob_pattern_matcher_unit
// Shell-style wildcard matcher built as a row of element cells.
// ---------------------------------------------------------------------------
// Every word (pattern byte, end of pattern, text byte, end of text) is taken
// back to back, so a text streams at one byte per clock while input is not
// stalled. The figure is set by the cell row: all positions step in parallel
// and the star closure ripples through the row in the same cycle. The result
// word for an end of text is held in an output register set on acceptance;
// while that word waits and the receiver is not ready, input of any kind
// stalls. No clearing pass runs after reset.
`include "assert_macros.svh"

module glob_pattern_matcher_unit #(
  parameter int unsigned MaxElements = gpm_pkg::MaxElementsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);
  import gpm_pkg::*;

  localparam int unsigned CW = $clog2(MaxElements + 1);
  localparam int unsigned IW = (MaxElements > 1) ? $clog2(MaxElements) : 1;

  op_e                  op;
  logic                 acc;
  cell_cmd_t            cmd;
  logic [IW-1:0]        idx;
  logic [CW-1:0]        cnt;
  logic                 ovf, done;
  logic [MaxElements:0] start, base, act_q, act_d, act_n;
  logic [MaxElements:0] step, clos;
  logic                 out_valid_q, matched_q, ovf_out_q;

  assign op         = op_e'(op_i);
  // skid on the result register: stall only when it is full and not draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  gpm_compiler #(.MaxElements(MaxElements)) u_compiler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .op_i    (op),
    .byte_i  (data_byte_i),
    .cmd_o   (cmd),
    .idx_o   (idx),
    .cnt_o   (cnt),
    .ovf_o   (ovf),
    .done_o  (done),
    .start_o (start)
  );

  // before the pattern closes, the live set is the start set
  assign base    = done ? act_q : start;
  assign step[0] = 1'b0;
  assign clos[0] = 1'b0;

  for (genvar i = 0; i < MaxElements; i++) begin : g_cell
    gpm_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .sel_i   (idx == IW'(i)),
      .valid_i (cnt > CW'(i)),
      .base_i  (base[i]),
      .byte_i  (data_byte_i),
      .step_i  (step[i]),
      .close_i (clos[i]),
      .step_o  (step[i+1]),
      .close_o (clos[i+1]),
      .act_o   (act_n[i])
    );
  end

  // end position has no cell
  assign act_n[MaxElements] = step[MaxElements] | clos[MaxElements];

  always_comb begin
    act_d = act_q;
    if (acc) begin
      case (op)
        OP_PAT_BYTE:  act_d = act_q;
        OP_TEXT_BYTE: act_d = act_n;
        OP_PAT_END,
        OP_TEXT_END:  act_d = start;
        default:      act_d = act_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= {{MaxElements{1'b0}}, 1'b1};
      out_valid_q <= 1'b0;
    end else begin
      act_q <= act_d;
      if (acc && op == OP_TEXT_END) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && op == OP_TEXT_END) begin
      matched_q <= !ovf && base[cnt];
      ovf_out_q <= ovf;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_out_q;

  `GPM_ASSERT(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without a pending result")
  `GPM_ASSERT_NEXT(a_end_text_gives_word, clk_i, rst_ni, acc && op == OP_TEXT_END, out_valid_o, "end of text produced no result word")
  `GPM_ASSERT(a_overflow_no_match, clk_i, rst_ni, (out_valid_o && pattern_overflow_o) |-> !matched_o, "match reported on overflowed pattern")

endmodule

// ===== design/gpm_cell.sv =====
// ---------------------------------------------------------------------------
// gpm_cell
// One pattern element: kind, literal, 256-bit list set, and the step /
// star-closure logic for its position.
// ---------------------------------------------------------------------------
module gpm_cell (
  input  logic              clk_i,
  input  gpm_pkg::cell_cmd_t cmd_i,
  input  logic              sel_i,
  input  logic              valid_i,
  input  logic              base_i,
  input  logic [7:0]        byte_i,
  input  logic              step_i,
  input  logic              close_i,
  output logic              step_o,
  output logic              close_o,
  output logic              act_o
);
  import gpm_pkg::*;

  kind_e        kind_q;
  logic [7:0]   lit_q;
  logic [255:0] set_q, set_d;
  logic         hit, match, star, p, c;

  always_comb begin
    set_d = set_q;
    if (sel_i) begin
      if (cmd_i.elem_we && cmd_i.kind == K_LIST) begin
        set_d = '0;
      end else if (cmd_i.clear) begin
        set_d = '0;
      end else if (cmd_i.set_we) begin
        set_d = set_q | cmd_i.mask;
        if (cmd_i.negate) begin
          set_d = ~set_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    set_q <= set_d;
    if (sel_i && cmd_i.elem_we) begin
      kind_q <= cmd_i.kind;
      lit_q  <= cmd_i.lit;
    end
  end

  // an abandoned list reads empty in the cycle it is cleared
  assign hit  = set_q[byte_i] & ~(sel_i & cmd_i.clear);
  assign star = (kind_q == K_STAR);

  always_comb begin
    case (kind_q)
      K_LIT:   match = (lit_q == byte_i);
      K_ANY:   match = 1'b1;
      K_LIST:  match = hit;
      default: match = 1'b0;
    endcase
  end

  assign p       = step_i | (base_i & star & valid_i);
  assign c       = p | close_i;
  assign close_o = c & star & valid_i;
  assign step_o  = base_i & valid_i & match;
  assign act_o   = c;

endmodule

// ===== design/gpm_compiler.sv =====
// ---------------------------------------------------------------------------
// gpm_compiler
// Pattern byte parser: builds elements and list sets, tracks count,
// overflow and the start position vector.
// ---------------------------------------------------------------------------
module gpm_compiler #(
  parameter int unsigned MaxElements = gpm_pkg::MaxElementsDef,
  localparam int unsigned CW = $clog2(MaxElements + 1),
  localparam int unsigned IW = (MaxElements > 1) ? $clog2(MaxElements) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  gpm_pkg::op_e       op_i,
  input  logic [7:0]         byte_i,
  output gpm_pkg::cell_cmd_t cmd_o,
  output logic [IW-1:0]      idx_o,
  output logic [CW-1:0]      cnt_o,
  output logic               ovf_o,
  output logic               done_o,
  output logic [MaxElements:0] start_o
);
  import gpm_pkg::*;

  typedef enum logic [9:0] {
    M_OUT    = 10'b00_0000_0001,
    M_OPEN   = 10'b00_0000_0010,
    M_BANG   = 10'b00_0000_0100,
    M_ITEM   = 10'b00_0000_1000,
    M_ESC_LO = 10'b00_0001_0000,
    M_OCT_LO = 10'b00_0010_0000,
    M_LOW    = 10'b00_0100_0000,
    M_DASH   = 10'b00_1000_0000,
    M_ESC_HI = 10'b01_0000_0000,
    M_OCT_HI = 10'b10_0000_0000
  } mode_e;

  mode_e               mode_q, mode_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic                done_q, done_d;
  logic                neg_q, neg_d;
  logic [7:0]          rl_q, rl_d;
  logic [7:0]          oct_q, oct_d;
  logic [1:0]          dig_q, dig_d;
  logic [MaxElements:0] start_q, start_d;
  logic                allstar_q, allstar_d;

  always_comb begin
    logic [CW-1:0]       cnt_e, cnt_m1;
    logic                ovf_e, allstar_e;
    logic [MaxElements:0] start_e;
    mode_e               m;
    logic [7:0]          rl, lo, hi, vd_val, sum;
    logic                is_oct, rng_en, dash_en, close_en, ne;
    logic                do_item, item_ne, vd_en, vd_high, add_en;
    logic [2:0]          dig_n;
    kind_e               add_kind;
    logic [7:0]          add_lit;

    mode_d = mode_q; cnt_d = cnt_q; ovf_d = ovf_q; done_d = done_q;
    neg_d = neg_q; rl_d = rl_q; oct_d = oct_q; dig_d = dig_q;
    start_d = start_q; allstar_d = allstar_q;
    cmd_o = '0; idx_o = '0;
    cnt_e = cnt_q; ovf_e = ovf_q; allstar_e = allstar_q; start_e = start_q;
    m = mode_q; rl = rl_q; lo = '0; hi = '0; vd_val = '0; sum = '0;
    is_oct = (byte_i >= CH_ZERO) && (byte_i <= CH_SEVEN);
    rng_en = 1'b0; dash_en = 1'b0; close_en = 1'b0; ne = 1'b0;
    do_item = 1'b0; item_ne = 1'b0; vd_en = 1'b0; vd_high = 1'b0;
    add_en = 1'b0; add_kind = K_LIT; add_lit = '0; dig_n = '0;
    cnt_m1 = '0;

    if (acc_i && op_i == OP_PAT_BYTE) begin
      // first byte of a new pattern drops the old one
      if (done_q) begin
        cnt_e = '0; ovf_e = 1'b0; m = M_OUT; allstar_e = 1'b1;
        start_e = '0; start_e[0] = 1'b1;
        done_d = 1'b0;
      end
      // octal run ended by a non-digit: finish the value, then reparse
      if ((m == M_OCT_LO || m == M_OCT_HI) && !is_oct) begin
        if (m == M_OCT_HI) begin
          rng_en = 1'b1; lo = rl; hi = oct_q; m = M_ITEM;
        end else begin
          rl = oct_q; m = M_LOW;
        end
      end
      mode_d = m;
      case (m)
        M_OUT: begin
          mode_d = M_OUT;
          add_en = 1'b1;
          if (byte_i == CH_STAR) begin
            add_kind = K_STAR;
          end else if (byte_i == CH_QMARK) begin
            add_kind = K_ANY;
          end else if (byte_i == CH_LBRACK) begin
            add_kind = K_LIST; neg_d = 1'b0; mode_d = M_OPEN;
          end else begin
            add_kind = K_LIT; add_lit = byte_i;
          end
        end
        M_OPEN: begin
          if (byte_i == CH_BANG) begin
            neg_d = 1'b1; mode_d = M_BANG;
          end else begin
            do_item = 1'b1;
          end
        end
        M_BANG: begin
          do_item = 1'b1;
        end
        M_ITEM: begin
          do_item = 1'b1; item_ne = 1'b1;
        end
        M_ESC_LO, M_ESC_HI: begin
          if (is_oct) begin
            oct_d = {5'd0, byte_i[2:0]};
            dig_d = 2'd1;
            mode_d = (m == M_ESC_HI) ? M_OCT_HI : M_OCT_LO;
          end else begin
            vd_en = 1'b1; vd_val = byte_i; vd_high = (m == M_ESC_HI);
          end
        end
        M_OCT_LO, M_OCT_HI: begin
          sum = {oct_q[4:0], 3'd0} + {5'd0, byte_i[2:0]};
          dig_n = {1'b0, dig_q} + 3'd1;
          oct_d = sum;
          dig_d = dig_n[1:0];
          if (dig_n >= OCT_MAX_DIGITS) begin
            vd_en = 1'b1; vd_val = sum; vd_high = (m == M_OCT_HI);
          end
        end
        M_LOW: begin
          if (byte_i == CH_DASH) begin
            mode_d = M_DASH;
          end else begin
            rng_en = 1'b1; lo = rl; hi = rl;
            do_item = 1'b1; item_ne = 1'b1;
          end
        end
        M_DASH: begin
          if (byte_i == CH_RBRACK) begin
            // dangling dash: low byte and '-' both join
            rng_en = 1'b1; lo = rl; hi = rl; dash_en = 1'b1;
            close_en = 1'b1; ne = 1'b1;
          end else if (byte_i == CH_BSLASH) begin
            mode_d = M_ESC_HI;
          end else begin
            vd_en = 1'b1; vd_val = byte_i; vd_high = 1'b1;
          end
        end
        default: mode_d = M_OUT;
      endcase
      if (vd_en) begin
        if (vd_high) begin
          rng_en = 1'b1; lo = rl; hi = vd_val; mode_d = M_ITEM;
        end else begin
          rl = vd_val; mode_d = M_LOW;
        end
      end
      if (do_item) begin
        if (byte_i == CH_RBRACK) begin
          close_en = 1'b1; ne = item_ne;
        end else if (byte_i == CH_BSLASH) begin
          mode_d = M_ESC_LO;
        end else begin
          rl = byte_i; mode_d = M_LOW;
        end
      end
      if (close_en) begin
        mode_d = M_OUT;
      end
      rl_d = rl;
      cnt_d = cnt_e; ovf_d = ovf_e; start_d = start_e; allstar_d = allstar_e;

      if (add_en) begin
        if (!ovf_e && cnt_e < CW'(MaxElements)) begin
          cmd_o.elem_we = 1'b1;
          cmd_o.kind    = add_kind;
          cmd_o.lit     = add_lit;
          idx_o         = cnt_e[IW-1:0];
          cnt_d         = cnt_e + CW'(1);
          if (allstar_e && add_kind == K_STAR) begin
            start_d[cnt_e + CW'(1)] = 1'b1;
          end else begin
            allstar_d = 1'b0;
          end
        end else begin
          ovf_d = 1'b1;
        end
      end else if (!ovf_e && cnt_e != '0) begin
        cnt_m1 = cnt_e - CW'(1);
        idx_o  = cnt_m1[IW-1:0];
        cmd_o.negate = close_en && ne && neg_q;
        cmd_o.set_we = rng_en || dash_en || cmd_o.negate;
        for (int v = 0; v < 256; v++) begin
          cmd_o.mask[v] = (rng_en && 8'(v) >= lo && 8'(v) <= hi) ||
                          (dash_en && 8'(v) == CH_DASH);
        end
      end
    end else if (acc_i && !done_q) begin
      // implicit or explicit end of pattern; open list is dropped
      if (mode_q != M_OUT && !ovf_q && cnt_q != '0) begin
        cnt_m1 = cnt_q - CW'(1);
        idx_o = cnt_m1[IW-1:0];
        cmd_o.clear = 1'b1;
      end
      mode_d = M_OUT;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_OUT;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      done_q    <= 1'b0;
      neg_q     <= 1'b0;
      rl_q      <= '0;
      oct_q     <= '0;
      dig_q     <= '0;
      start_q   <= {{MaxElements{1'b0}}, 1'b1};
      allstar_q <= 1'b1;
    end else begin
      mode_q    <= mode_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      done_q    <= done_d;
      neg_q     <= neg_d;
      rl_q      <= rl_d;
      oct_q     <= oct_d;
      dig_q     <= dig_d;
      start_q   <= start_d;
      allstar_q <= allstar_d;
    end
  end

  assign cnt_o   = cnt_q;
  assign ovf_o   = ovf_q;
  assign done_o  = done_q;
  assign start_o = start_q;

endmodule
